### src/ascf_pkg.sv
// Shared types and constants for the ASCII time frame parser.
// No dependencies; every other file imports this package.
package ascf_pkg;

    localparam int FRAME_BYTES = 23;
    localparam int POS_W       = 5;
    localparam int CNT_W       = 12;

    localparam logic [POS_W-1:0] POS_MAX    = 5'd31;
    localparam logic [POS_W-1:0] POS_FULL   = 5'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] RESYNC_RST = 12'd3600;

    // input item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // control characters
    localparam logic [7:0] CH_START = 8'h5E;  // '^'
    localparam logic [7:0] CH_END   = 8'h24;  // '$'
    localparam logic [7:0] CH_NETOFF = 8'h2E; // '.'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

    localparam logic [2:0] WD_NONE = 3'd7;

    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    // letter sums of the weekday names, Sunday first
    localparam logic [6:0][7:0] DAY_SUMS = {
        8'hE8, 8'hE1, 8'hF1, 8'hE0, 8'hEE, 8'hEA, 8'hF6
    };

    typedef struct packed {
        logic       time_write;
        logic [7:0] seconds_bcd;
        logic [7:0] minutes_bcd;
        logic [7:0] hours_bcd;
        logic [2:0] weekday;
        logic [7:0] day_bcd;
        logic [7:0] month_bcd;
        logic [7:0] year_bcd;
        logic [7:0] century_bcd;
        logic       network_on;
    } t_result;

endpackage

### src/ascf_frame_store.sv
// Frame character store: 23 byte registers written at the write position.
// Depends on ascf_pkg.
module ascf_frame_store
    import ascf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [POS_W-1:0] i_addr,
    input  logic [7:0]       i_data,
    output t_frame           o_frame
);

    t_frame r_frame;

    // no reset: entries are only read after a full frame was written
    for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_we && (i_addr == POS_W'(g))) begin
                r_frame[g] <= i_data;
            end
        end
    end

    assign o_frame = r_frame;

endmodule

### src/ascf_decoder.sv
// Frame decoder: packs digit pairs into BCD and matches the weekday name.
// Depends on ascf_pkg.
module ascf_decoder
    import ascf_pkg::*;
(
    input  t_frame  i_frame,
    input  logic    i_decode,
    input  logic    i_net,
    output t_result o_result
);

    function automatic logic [7:0] bcd_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] l;
        h = hi - CH_ZERO;
        l = lo - CH_ZERO;
        return {h[3:0], 4'b0000} | l;
    endfunction

    logic [7:0] w_sum;
    logic [2:0] w_wd;

    assign w_sum = i_frame[11] + i_frame[12] + i_frame[13];

    // scan downward so the lowest matching day wins
    always_comb begin
        w_wd = WD_NONE;
        for (int i = 6; i >= 0; i--) begin
            if (w_sum == DAY_SUMS[i]) begin
                w_wd = 3'(i);
            end
        end
    end

    always_comb begin
        o_result = '0;
        if (i_decode) begin
            o_result.time_write  = 1'b1;
            o_result.seconds_bcd = bcd_pair(i_frame[21], i_frame[22]);
            o_result.minutes_bcd = bcd_pair(i_frame[18], i_frame[19]);
            o_result.hours_bcd   = bcd_pair(i_frame[15], i_frame[16]);
            o_result.weekday     = w_wd;
            o_result.day_bcd     = bcd_pair(i_frame[8], i_frame[9]);
            o_result.month_bcd   = bcd_pair(i_frame[5], i_frame[6]);
            o_result.year_bcd    = bcd_pair(i_frame[2], i_frame[3]);
            o_result.century_bcd = bcd_pair(i_frame[0], i_frame[1]);
        end
        o_result.network_on = i_net;
    end

endmodule

### src/ascf_out_skid.sv
// Result register with a one-entry skid stage behind it.
// Depends on ascf_pkg.
module ascf_out_skid
    import ascf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign o_ready = !r_skid_valid;
    assign w_pop   = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_valid) begin
            if (!r_out_valid || w_pop) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (w_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### src/ascii_time_frame_parser.sv
// Top level of the ASCII time frame parser: control state, frame store,
// decoder and result buffer. Depends on ascf_pkg and the ascf_* modules.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_ready      i_func, i_rx_byte
//  result    out        o_out_valid / i_out_ready    o_time_write .. o_network_on
//  config    in         i_cfg_we (no wait)           i_cfg_data (resync seconds)
//
// One transaction per cycle while o_in_ready is high: the control state (write
// position, update mark, network flag, seconds counter) and the result register,
// or the skid stage if it is full, load at the edge that takes a transaction.
// Reset is synchronous and active low; it clears the control state and sets
// the resync limit to 3600. The frame store has no reset.
// A stalled result side is absorbed by a one-entry skid stage; input ready
// drops only while that stage is occupied.
module ascii_time_frame_parser
    import ascf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_func,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_time_write,
    output logic [7:0]       o_seconds_bcd,
    output logic [7:0]       o_minutes_bcd,
    output logic [7:0]       o_hours_bcd,
    output logic [2:0]       o_weekday,
    output logic [7:0]       o_day_bcd,
    output logic [7:0]       o_month_bcd,
    output logic [7:0]       o_year_bcd,
    output logic [7:0]       o_century_bcd,
    output logic             o_network_on
);

    logic [POS_W-1:0] r_write_pos, n_write_pos;
    logic             r_updated, n_updated;
    logic             r_net, n_net;
    logic [CNT_W-1:0] r_sec_cnt, n_sec_cnt;
    logic [CNT_W-1:0] r_resync;

    logic             w_accept;
    logic [CNT_W-1:0] w_cnt0;
    logic [CNT_W-1:0] w_cnt1;
    logic             w_mark0;
    logic             w_store_we;
    logic             w_decode;
    t_frame           w_frame;
    t_result          w_result;
    t_result          w_out;

    assign w_accept = i_in_valid && o_in_ready;

    // resync check ahead of the item: stale count clears the update mark
    assign w_cnt0  = (r_sec_cnt > r_resync) ? '0 : r_sec_cnt;
    assign w_mark0 = (r_sec_cnt > r_resync) ? 1'b0 : r_updated;
    assign w_cnt1  = w_cnt0 + 1'b1;

    always_comb begin
        n_write_pos = r_write_pos;
        n_updated   = w_mark0;
        n_net       = r_net;
        n_sec_cnt   = w_cnt0;
        w_store_we  = 1'b0;
        w_decode    = 1'b0;
        if (i_func == FUNC_TICK) begin
            // count the tick, then check the limit again
            if (w_cnt1 > r_resync) begin
                n_sec_cnt = '0;
                n_updated = 1'b0;
            end else begin
                n_sec_cnt = w_cnt1;
            end
        end else begin
            case (i_rx_byte)
                CH_NETOFF: n_net = 1'b0;
                CH_START:  n_write_pos = '0;
                CH_END: begin
                    n_net = 1'b1;
                    if (!w_mark0) begin
                        n_updated = 1'b1;
                        w_decode  = (r_write_pos == POS_FULL);
                    end
                end
                default: begin
                    // store while room is left, then saturate the position
                    w_store_we = (r_write_pos < POS_FULL);
                    if (r_write_pos != POS_MAX) begin
                        n_write_pos = r_write_pos + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos <= '0;
            r_updated   <= 1'b0;
            r_net       <= 1'b0;
            r_sec_cnt   <= '0;
            r_resync    <= RESYNC_RST;
        end else begin
            if (w_accept) begin
                r_write_pos <= n_write_pos;
                r_updated   <= n_updated;
                r_net       <= n_net;
                r_sec_cnt   <= n_sec_cnt;
            end
            if (i_cfg_we) begin
                r_resync <= i_cfg_data;
            end
        end
    end

    ascf_frame_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_store_we),
        .i_addr  (r_write_pos),
        .i_data  (i_rx_byte),
        .o_frame (w_frame)
    );

    ascf_decoder u_decoder (
        .i_frame  (w_frame),
        .i_decode (w_decode),
        .i_net    (n_net),
        .o_result (w_result)
    );

    ascf_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (w_result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .i_ready (i_out_ready)
    );

    assign o_time_write  = w_out.time_write;
    assign o_seconds_bcd = w_out.seconds_bcd;
    assign o_minutes_bcd = w_out.minutes_bcd;
    assign o_hours_bcd   = w_out.hours_bcd;
    assign o_weekday     = w_out.weekday;
    assign o_day_bcd     = w_out.day_bcd;
    assign o_month_bcd   = w_out.month_bcd;
    assign o_year_bcd    = w_out.year_bcd;
    assign o_century_bcd = w_out.century_bcd;
    assign o_network_on  = w_out.network_on;

`ifndef SYNTHESIS
    // an accepted end character always leaves the update mark set
    a_end_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_BYTE && i_rx_byte == CH_END) |=> r_updated)
        else $error("update mark not set after end character");

    // a start character rewinds the write position
    a_start_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_BYTE && i_rx_byte == CH_START)
        |=> (r_write_pos == '0))
        else $error("write position not cleared by start character");

    // after a tick the counter never sits above the limit
    a_tick_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_TICK) |=> (r_sec_cnt <= $past(r_resync)))
        else $error("seconds counter above resync limit after tick");

    // input stalls only while a result is waiting in the output register
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");
`endif

endmodule

### sim/ascii_time_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the ASCII time frame parser: follows the parser state from
// accepted transactions, predicts each result and compares it field by field.
// Depends on ascf_pkg for the frame length, counter width and control characters.
module ascii_time_frame_checker
    import ascf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_func,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic             i_time_write,
    input  logic [7:0]       i_seconds_bcd,
    input  logic [7:0]       i_minutes_bcd,
    input  logic [7:0]       i_hours_bcd,
    input  logic [2:0]       i_weekday,
    input  logic [7:0]       i_day_bcd,
    input  logic [7:0]       i_month_bcd,
    input  logic [7:0]       i_year_bcd,
    input  logic [7:0]       i_century_bcd,
    input  logic             i_network_on,
    output int               o_results_due,
    output int               o_mismatches,
    output int               o_frames,
    output int               o_items
);

    localparam logic [CNT_W-1:0] RESYNC_AFTER_RESET = 12'd3600;
    localparam logic [4:0]       WPOS_TOP           = 5'd31;
    localparam logic [2:0]       NO_WEEKDAY         = 3'd7;

    // letter sums of SUN MON TUE WED THU FRI SAT
    localparam logic [0:6][7:0] NAME_SUMS = {
        8'hF6, 8'hEA, 8'hEE, 8'hE0, 8'hF1, 8'hE1, 8'hE8
    };

    typedef struct packed {
        logic       time_write;
        logic [7:0] seconds;
        logic [7:0] minutes;
        logic [7:0] hours;
        logic [2:0] weekday;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
        logic       network_on;
    } t_clock_fields;

    logic [7:0]       frame_bytes [FRAME_BYTES];
    logic [4:0]       wr_pos;
    logic             time_set;
    logic             net_up;
    logic [CNT_W-1:0] sec_count;
    logic [CNT_W-1:0] resync_lim;
    t_clock_fields    times_due [$];
    int               mismatches;
    int               frames;
    int               items;

    initial begin
        mismatches = 0;
        frames     = 0;
        items      = 0;
    end

    function automatic logic [7:0] bcd_at(int hi, int lo);
        logic [7:0] h;
        logic [7:0] l;
        h = frame_bytes[hi] - CH_ZERO;
        l = frame_bytes[lo] - CH_ZERO;
        return (h << 4) | l;
    endfunction

    function automatic void resync_clear();
        if (sec_count > resync_lim) begin
            sec_count = '0;
            time_set  = 1'b0;
        end
    endfunction

    // Advance the parser state by one transaction and return its result.
    function automatic t_clock_fields parse_item(logic func, logic [7:0] ch);
        t_clock_fields r;
        logic [7:0]    sum;
        r = '0;
        resync_clear();
        if (func == FUNC_TICK) begin
            sec_count = sec_count + 1'b1;
            resync_clear();
        end else if (ch == CH_NETOFF) begin
            net_up = 1'b0;
        end else if (ch == CH_START) begin
            wr_pos = '0;
        end else if (ch == CH_END) begin
            net_up = 1'b1;
            if (!time_set) begin
                time_set = 1'b1;
                if (wr_pos == FRAME_BYTES) begin
                    // layout: CCYY-MM-DD WWW hh:mm:ss
                    sum = frame_bytes[11] + frame_bytes[12] + frame_bytes[13];
                    r.weekday = NO_WEEKDAY;
                    for (int d = 6; d >= 0; d--)
                        if (sum == NAME_SUMS[d]) r.weekday = 3'(d);
                    r.time_write = 1'b1;
                    r.seconds    = bcd_at(21, 22);
                    r.minutes    = bcd_at(18, 19);
                    r.hours      = bcd_at(15, 16);
                    r.day        = bcd_at(8, 9);
                    r.month      = bcd_at(5, 6);
                    r.year       = bcd_at(2, 3);
                    r.century    = bcd_at(0, 1);
                    frames++;
                end
            end
        end else begin
            if (wr_pos < FRAME_BYTES) frame_bytes[wr_pos] = ch;
            if (wr_pos != WPOS_TOP) wr_pos = wr_pos + 1'b1;
        end
        r.network_on = net_up;
        return r;
    endfunction

    function automatic void note_field(string tag, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, tag, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_clock_fields got;
        t_clock_fields want;
        if (!i_rst_n) begin
            wr_pos     = '0;
            time_set   = 1'b0;
            net_up     = 1'b0;
            sec_count  = '0;
            resync_lim = RESYNC_AFTER_RESET;
            times_due.delete();
        end else begin
            if (i_cfg_we) resync_lim = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got = {i_time_write, i_seconds_bcd, i_minutes_bcd, i_hours_bcd, i_weekday,
                       i_day_bcd, i_month_bcd, i_year_bcd, i_century_bcd, i_network_on};
                if (times_due.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing actual %0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = times_due.pop_front();
                    note_field("time_write", 8'(want.time_write), 8'(got.time_write));
                    note_field("seconds_bcd", want.seconds, got.seconds);
                    note_field("minutes_bcd", want.minutes, got.minutes);
                    note_field("hours_bcd", want.hours, got.hours);
                    note_field("weekday", 8'(want.weekday), 8'(got.weekday));
                    note_field("day_bcd", want.day, got.day);
                    note_field("month_bcd", want.month, got.month);
                    note_field("year_bcd", want.year, got.year);
                    note_field("century_bcd", want.century, got.century);
                    note_field("network_on", 8'(want.network_on), 8'(got.network_on));
                end
            end
            if (i_in_valid && i_in_ready) begin
                times_due.push_back(parse_item(i_func, i_rx_byte));
                items++;
            end
        end
        o_results_due <= times_due.size();
        o_mismatches  <= mismatches;
        o_frames      <= frames;
        o_items       <= items;
    end

endmodule

### sim/ascii_time_frame_parser_test.sv
`timescale 1ns / 100ps
// Testbench top for the ASCII time frame parser: clock, reset, stimulus and
// verdict. Depends on ascf_pkg, the parser RTL and ascii_time_frame_checker.
module ascii_time_frame_parser_test;
    import ascf_pkg::*;

    // sensible frame for the directed part; first and last bytes get overridden
    localparam logic [8*FRAME_BYTES-1:0] FIRST_FRAME = "2099-12-31 SAT 23:59:59";
    localparam logic [0:6][23:0] DAY_NAMES = {
        "SUN", "MON", "TUE", "WED", "THU", "FRI", "SAT"
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_func;
    logic [7:0]       i_rx_byte;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_time_write;
    logic [7:0]       o_seconds_bcd;
    logic [7:0]       o_minutes_bcd;
    logic [7:0]       o_hours_bcd;
    logic [2:0]       o_weekday;
    logic [7:0]       o_day_bcd;
    logic [7:0]       o_month_bcd;
    logic [7:0]       o_year_bcd;
    logic [7:0]       o_century_bcd;
    logic             o_network_on;

    int               results_due;
    int               mismatches;
    int               frames_seen;
    int               items_seen;

    int               sent;
    bit               steady;
    logic [CNT_W-1:0] resync_now;
    int               settings_used;

    always #5 i_clk = ~i_clk;

    ascii_time_frame_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_time_write  (o_time_write),
        .o_seconds_bcd (o_seconds_bcd),
        .o_minutes_bcd (o_minutes_bcd),
        .o_hours_bcd   (o_hours_bcd),
        .o_weekday     (o_weekday),
        .o_day_bcd     (o_day_bcd),
        .o_month_bcd   (o_month_bcd),
        .o_year_bcd    (o_year_bcd),
        .o_century_bcd (o_century_bcd),
        .o_network_on  (o_network_on)
    );

    ascii_time_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_time_write  (o_time_write),
        .i_seconds_bcd (o_seconds_bcd),
        .i_minutes_bcd (o_minutes_bcd),
        .i_hours_bcd   (o_hours_bcd),
        .i_weekday     (o_weekday),
        .i_day_bcd     (o_day_bcd),
        .i_month_bcd   (o_month_bcd),
        .i_year_bcd    (o_year_bcd),
        .i_century_bcd (o_century_bcd),
        .i_network_on  (o_network_on),
        .o_results_due (results_due),
        .o_mismatches  (mismatches),
        .o_frames      (frames_seen),
        .o_items       (items_seen)
    );

    // Pick the idle gap before the next input transaction: mostly none or
    // short, now and then long; none at all while a steady stretch runs.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one transaction and hold it until the parser takes it. Called on
    // a rising edge; valid is only lowered when a gap follows, so it never
    // gets two assignments in the same step.
    task automatic push_item(logic func, logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_rx_byte  <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    // Ticks carry a random character that the parser must ignore.
    task automatic tick_run(int n);
        repeat (n) push_item(FUNC_TICK, 8'($urandom));
    endtask

    // Character at one position of a "CCYY-MM-DD WWW hh:mm:ss" frame. Digits
    // are now and then any byte so the BCD math sees odd values; day 7 picks
    // random capitals, which usually match no weekday.
    function automatic logic [7:0] frame_char(int pos, int day);
        logic [7:0] digit;
        if ($urandom_range(0, 15) == 0)
            digit = 8'($urandom);
        else
            digit = 8'($urandom_range(CH_ZERO, CH_ZERO + 9));
        case (pos)
            4, 7:       return "-";
            10, 14:     return " ";
            17, 20:     return ":";
            11, 12, 13: begin
                if (day < 7) return DAY_NAMES[day][8*(13-pos) +: 8];
                return 8'($urandom_range(65, 90));
            end
            default:    return digit;
        endcase
    endfunction

    // Send a frame of len characters closed by '$'; lead adds the '^'.
    task automatic send_frame(int len, bit lead);
        int day;
        day = $urandom_range(0, 7);
        if (lead) push_item(FUNC_BYTE, CH_START);
        for (int p = 0; p < len; p++) push_item(FUNC_BYTE, frame_char(p, day));
        push_item(FUNC_BYTE, CH_END);
    endtask

    // Drop valid and hold until every result is back, plus a little margin.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic settle_and_write(logic [CNT_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        resync_now = value;
        settings_used++;
    endtask

    // Random traffic: mostly whole frames with random content, interleaved
    // with tick bursts sized to small resync limits, plus short and overlong
    // frames, stray bytes and lone control characters.
    task automatic run_mix(int budget);
        int stop_at;
        int kind;
        int span;
        stop_at = sent + budget;
        span = (resync_now < 45) ? int'(resync_now) + 2 : 8;
        while (sent < stop_at) begin
            steady = ($urandom_range(0, 5) == 0);
            kind   = $urandom_range(0, 99);
            if (kind < 45)
                send_frame(FRAME_BYTES, 1'b1);
            else if (kind < 50)
                send_frame(FRAME_BYTES, 1'b0);   // no restart: write position runs on
            else if (kind < 65)
                tick_run($urandom_range(1, span));
            else if (kind < 73)
                send_frame($urandom_range(0, FRAME_BYTES - 1), 1'b1);
            else if (kind < 80)
                send_frame($urandom_range(FRAME_BYTES + 1, 36), 1'b1);
            else if (kind < 90)
                repeat ($urandom_range(1, 5)) push_item(FUNC_BYTE, 8'($urandom));
            else if (kind < 95)
                push_item(FUNC_BYTE, CH_NETOFF);
            else
                push_item(FUNC_BYTE, CH_END);
        end
    endtask

    // Result side: long unbroken stretches, short bursts, short stalls and
    // the odd long stall.
    initial begin : out_side
        int r;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else if (r < 60) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else if (r < 95) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= FUNC_BYTE;
        i_rx_byte     <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        sent          = 0;
        steady        = 1'b0;
        resync_now    = 12'd3600;
        settings_used = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: network off, a tick, then one frame with a zero byte in
        // front and an all-ones byte at the end, decoded on the first '$'.
        // The second '$' finds the update already done.
        push_item(FUNC_BYTE, CH_NETOFF);
        push_item(FUNC_TICK, 8'hFF);
        push_item(FUNC_BYTE, CH_START);
        for (int p = 0; p < FRAME_BYTES; p++)
            push_item(FUNC_BYTE, (p == 0) ? 8'h00 :
                                 (p == FRAME_BYTES - 1) ? 8'hFF :
                                 FIRST_FRAME[8*(FRAME_BYTES-1-p) +: 8]);
        push_item(FUNC_BYTE, CH_END);
        push_item(FUNC_BYTE, CH_END);
        push_item(FUNC_BYTE, CH_NETOFF);

        // Zero limit: every tick clears the update mark, so frames decode often.
        settle_and_write(12'd0);
        run_mix(450);
        settle_and_write(12'd2);
        run_mix(350);

        // Top of the range: the limit is never reached; one update at most.
        settle_and_write(12'd4094);
        run_mix(60);
        settle_and_write(12'd4095);
        run_mix(60);

        settle_and_write(12'($urandom_range(3, 40)));
        run_mix(400);
        settle_and_write(12'd1);
        run_mix(300);
        settle_and_write(12'd3600);
        run_mix(120);

        wait_drained();
        $display("Covered %0d transactions under %0d resync settings, %0d frames decoded,",
                 items_seen, settings_used, frames_seen);
        $display("with short, overlong and broken frames, tick runs past small limits");
        $display("and the two largest limits.");
        if (mismatches == 0 && results_due == 0) begin
            $display("PASS ascii_time_frame_parser");
        end else begin
            $display("FAIL ascii_time_frame_parser");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : watchdog
        #25_000_000;
        $display("FAIL ascii_time_frame_parser");
        $finish;
    end

endmodule
